// ===== hdl/nmea_sentence_framer_checker_macros.svh =====
// Assertion macros for the NMEA sentence framer and checker.
// Users must have signals named clock and reset in scope.
`ifndef NMEA_SENTENCE_FRAMER_CHECKER_MACROS_SVH
`define NMEA_SENTENCE_FRAMER_CHECKER_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define NSFC_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define NSFC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/nsfc_pkg.sv =====
// Package for the NMEA sentence framer and checker: character codes, limits,
// stage structs and the hex digit decoder. Depends on nothing.
package nsfc_pkg;

   localparam logic [7:0] CHAR_DOLLAR = 8'h24;
   localparam logic [7:0] CHAR_STAR   = 8'h2A;
   localparam logic [7:0] CHAR_COMMA  = 8'h2C;
   localparam logic [7:0] CHAR_CR     = 8'h0D;
   localparam logic [7:0] CHAR_LF     = 8'h0A;

   localparam logic [23:0] GGA_TEXT = "GGA";
   localparam logic [23:0] RMC_TEXT = "RMC";

   localparam int unsigned MIN_REPORT_LEN = 6;
   localparam int unsigned MIN_CHECK_LEN  = 9;
   localparam int unsigned MAX_FIELDS     = 16;
   localparam int unsigned KIND_POS_FIRST = 3;

   localparam logic [1:0] KIND_OTHER = 2'd0;
   localparam logic [1:0] KIND_GGA   = 2'd1;
   localparam logic [1:0] KIND_RMC   = 2'd2;

   typedef struct packed {
      logic       valid;
      logic [7:0] rx_byte;
   } byte_beat_type;

   typedef struct packed {
      logic       valid;
      logic       checksum_ok;
      logic [7:0] computed_sum;
      logic [7:0] received_sum;
      logic [6:0] line_length;
      logic [1:0] sentence_kind;
      logic [4:0] field_count;
   } line_result_type;

   // Returns {is_digit, value} for one ASCII character.
   function automatic logic [4:0] hex_digit(input logic [7:0] c);
      logic [7:0] diff;
      logic [4:0] res;
      diff = 8'h00;
      res  = 5'b0;
      case (c) inside
         [8'h30:8'h39]: begin
            diff = c - 8'h30;
            res  = {1'b1, diff[3:0]};
         end
         [8'h61:8'h66]: begin
            diff = c - 8'h57;
            res  = {1'b1, diff[3:0]};
         end
         [8'h41:8'h46]: begin
            diff = c - 8'h37;
            res  = {1'b1, diff[3:0]};
         end
         default: res = 5'b0;
      endcase
      return res;
   endfunction

endpackage

// ===== hdl/nsfc_req_if.sv =====
// Input channel of the NMEA sentence framer and checker: one received byte a beat.
// Standalone; no package needed.
interface nsfc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

// ===== hdl/nsfc_rsp_if.sv =====
// Result channel of the NMEA sentence framer and checker: one checked line a beat.
// Standalone; no package needed.
interface nsfc_rsp_if;
   logic       valid;
   logic       ready;
   logic       checksum_ok;
   logic [7:0] computed_sum;
   logic [7:0] received_sum;
   logic [6:0] line_length;
   logic [1:0] sentence_kind;
   logic [4:0] field_count;

   modport source (output valid, output checksum_ok, output computed_sum,
                   output received_sum, output line_length, output sentence_kind,
                   output field_count, input ready);
   modport sink (input valid, input checksum_ok, input computed_sum,
                 input received_sum, input line_length, input sentence_kind,
                 input field_count, output ready);
endinterface

// ===== hdl/nsfc_in_stage.sv =====
// Input register of the NMEA sentence framer and checker.
// Depends on nsfc_pkg and nsfc_req_if.
module nsfc_in_stage import nsfc_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   nsfc_req_if.sink      req,
   input  logic          advance,
   output byte_beat_type beat
);

   logic       valid_ff;
   logic       valid_in;
   logic [7:0] byte_ff;

   // The register takes a new beat when empty or when its beat moves on.
   assign req.ready = !valid_ff || advance;
   assign valid_in  = req.ready ? req.valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req.ready && req.valid) begin
         byte_ff <= req.rx_byte;
      end
   end

   assign beat.valid   = valid_ff;
   assign beat.rx_byte = byte_ff;

endmodule

// ===== hdl/nsfc_line_tracker.sv =====
// Line state of the NMEA sentence framer and checker: framing, running XOR,
// star and hex tracking, kind and field count. Depends on nsfc_pkg.
module nsfc_line_tracker import nsfc_pkg::*; #(
   parameter int LINE_CAPACITY = 96
) (
   input  logic            clock,
   input  logic            reset,
   input  byte_beat_type   beat,
   input  logic            advance,
   output line_result_type result
);

   localparam int LW = $clog2(LINE_CAPACITY);
   localparam logic [LW-1:0] LEN_LIMIT = LW'(LINE_CAPACITY - 1);

   logic [LW-1:0] len_ff, len_in;
   logic [7:0]    xor_ff, xor_in;
   logic [7:0]    star_sum_ff, star_sum_in;
   logic          star_ff, star_in;
   logic [1:0]    after_ff, after_in;
   logic [7:0]    hex_ff, hex_in;
   logic          hex_open_ff, hex_open_in;
   logic [1:0]    kind_ff, kind_in;
   logic [4:0]    sep_ff, sep_in;

   logic [7:0] c;
   logic       is_eol;
   logic       is_star;
   logic [4:0] digit;
   logic [7:0] comp_sum;
   logic [7:0] recv_sum;

   assign c       = beat.rx_byte;
   assign is_eol  = (c == CHAR_CR) || (c == CHAR_LF);
   assign is_star = (c == CHAR_STAR);
   assign digit   = hex_digit(c);

   always_comb begin
      len_in      = len_ff;
      xor_in      = xor_ff;
      star_sum_in = star_sum_ff;
      star_in     = star_ff;
      after_in    = after_ff;
      hex_in      = hex_ff;
      hex_open_in = hex_open_ff;
      kind_in     = kind_ff;
      sep_in      = sep_ff;
      if (beat.valid && advance) begin
         if (c == CHAR_DOLLAR || is_eol) begin
            // Both a dollar and a line end restart all line state.
            len_in      = (c == CHAR_DOLLAR) ? LW'(1) : '0;
            xor_in      = 8'h00;
            star_sum_in = 8'h00;
            star_in     = 1'b0;
            after_in    = 2'd0;
            hex_in      = 8'h00;
            hex_open_in = 1'b0;
            kind_in     = (c == CHAR_DOLLAR) ? 2'b11 : 2'b00;
            sep_in      = 5'd1;
         end else if (len_ff != '0 && len_ff < LEN_LIMIT) begin
            if (len_ff == LW'(KIND_POS_FIRST)) begin
               if (c != GGA_TEXT[23:16]) kind_in[0] = 1'b0;
               if (c != RMC_TEXT[23:16]) kind_in[1] = 1'b0;
            end else if (len_ff == LW'(KIND_POS_FIRST + 1)) begin
               if (c != GGA_TEXT[15:8]) kind_in[0] = 1'b0;
               if (c != RMC_TEXT[15:8]) kind_in[1] = 1'b0;
            end else if (len_ff == LW'(KIND_POS_FIRST + 2)) begin
               if (c != GGA_TEXT[7:0]) kind_in[0] = 1'b0;
               if (c != RMC_TEXT[7:0]) kind_in[1] = 1'b0;
            end
            if (is_star) begin
               // Each star restarts the checksum field; the last one wins.
               star_sum_in = xor_ff;
               star_in     = 1'b1;
               after_in    = 2'd0;
               hex_in      = 8'h00;
               hex_open_in = 1'b1;
            end else begin
               if (star_ff && after_ff < 2'd2) after_in = after_ff + 2'd1;
               if (hex_open_ff) begin
                  if (digit[4]) hex_in = {hex_ff[3:0], digit[3:0]};
                  else hex_open_in = 1'b0;
               end
            end
            if ((c == CHAR_COMMA || is_star) && sep_ff < 5'(MAX_FIELDS)) begin
               sep_in = sep_ff + 5'd1;
            end
            xor_in = xor_ff ^ c;
            len_in = len_ff + LW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff      <= '0;
         xor_ff      <= 8'h00;
         star_sum_ff <= 8'h00;
         star_ff     <= 1'b0;
         after_ff    <= 2'd0;
         hex_ff      <= 8'h00;
         hex_open_ff <= 1'b0;
         kind_ff     <= 2'b00;
         sep_ff      <= 5'd1;
      end else begin
         len_ff      <= len_in;
         xor_ff      <= xor_in;
         star_sum_ff <= star_sum_in;
         star_ff     <= star_in;
         after_ff    <= after_in;
         hex_ff      <= hex_in;
         hex_open_ff <= hex_open_in;
         kind_ff     <= kind_in;
         sep_ff      <= sep_in;
      end
   end

   assign comp_sum = star_ff ? star_sum_ff : 8'h00;
   assign recv_sum = star_ff ? hex_ff : 8'h00;

   always_comb begin
      result.valid        = beat.valid && is_eol && (len_ff > LW'(MIN_REPORT_LEN));
      result.checksum_ok  = (len_ff >= LW'(MIN_CHECK_LEN)) && star_ff &&
                            (after_ff == 2'd2) && (comp_sum == recv_sum);
      result.computed_sum = comp_sum;
      result.received_sum = recv_sum;
      result.line_length  = 7'(len_ff);
      result.field_count  = sep_ff;
      if (kind_ff[0]) result.sentence_kind = KIND_GGA;
      else if (kind_ff[1]) result.sentence_kind = KIND_RMC;
      else result.sentence_kind = KIND_OTHER;
   end

endmodule

// ===== hdl/nsfc_out_stage.sv =====
// Result register of the NMEA sentence framer and checker.
// Depends on nsfc_pkg and nsfc_rsp_if.
module nsfc_out_stage import nsfc_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  line_result_type result,
   output logic            advance,
   nsfc_rsp_if.source      rsp
);

   logic            valid_ff;
   logic            valid_in;
   line_result_type data_ff;

   // The pipe moves whenever the result register is empty or being drained.
   assign advance  = !valid_ff || rsp.ready;
   assign valid_in = advance ? result.valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && result.valid) begin
         data_ff <= result;
      end
   end

   assign rsp.valid         = valid_ff;
   assign rsp.checksum_ok   = data_ff.checksum_ok;
   assign rsp.computed_sum  = data_ff.computed_sum;
   assign rsp.received_sum  = data_ff.received_sum;
   assign rsp.line_length   = data_ff.line_length;
   assign rsp.sentence_kind = data_ff.sentence_kind;
   assign rsp.field_count   = data_ff.field_count;

endmodule

// ===== hdl/nmea_sentence_framer_checker.sv =====
// Top level of the NMEA sentence framer and checker.
// Depends on nsfc_pkg, nsfc_req_if, nsfc_rsp_if, the three stage modules and the macros header.
//
//   Channel   Direction  Beat carries
//   req_bus   in         rx_byte: one received character
//   rsp_bus   out        checksum_ok, computed_sum, received_sum,
//                        line_length, sentence_kind, field_count
//
// One byte a cycle is accepted unless the pipe stalls; the line state update
// is a single pass of logic between the input register and the result register.
// A line end's result is registered in the result register after its byte has passed the input register.
// Synchronous reset clears the valid flags and all line state.
// A stalled result register holds the pipe; the input register still takes
// one more byte while it is empty.
`include "nmea_sentence_framer_checker_macros.svh"
module nmea_sentence_framer_checker import nsfc_pkg::*; #(
   parameter int LINE_CAPACITY = 96
) (
   input  logic       clock,
   input  logic       reset,
   nsfc_req_if.sink   req_bus,
   nsfc_rsp_if.source rsp_bus
);

   byte_beat_type   in_beat;
   line_result_type line_result;
   logic            advance;

   nsfc_in_stage u_in_stage (
      .clock   (clock),
      .reset   (reset),
      .req     (req_bus),
      .advance (advance),
      .beat    (in_beat)
   );

   nsfc_line_tracker #(
      .LINE_CAPACITY (LINE_CAPACITY)
   ) u_line_tracker (
      .clock   (clock),
      .reset   (reset),
      .beat    (in_beat),
      .advance (advance),
      .result  (line_result)
   );

   nsfc_out_stage u_out_stage (
      .clock   (clock),
      .reset   (reset),
      .result  (line_result),
      .advance (advance),
      .rsp     (rsp_bus)
   );

   `NSFC_ASSERT_NOW(a_ok_sums_match, rsp_bus.valid && rsp_bus.checksum_ok, rsp_bus.computed_sum == rsp_bus.received_sum, "checksum_ok with differing sums")
   `NSFC_ASSERT_NOW(a_field_range, rsp_bus.valid, rsp_bus.field_count != 5'd0 && rsp_bus.field_count <= 5'd16, "field_count out of range")
   `NSFC_ASSERT_NEXT(a_stall_holds_byte, in_beat.valid && !advance, in_beat.valid && $stable(in_beat.rx_byte), "stalled input byte lost")
   `NSFC_ASSERT_NOW(a_result_needs_beat, line_result.valid, in_beat.valid, "result without an input byte")

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 100ps
// Testbench for nmea_sentence_framer_checker: streams NMEA lines and noise
// into the byte channel and checks every line result against a local predictor.
// Depends on nsfc_pkg, nsfc_req_if, nsfc_rsp_if and the RTL under hdl.
module tb;
   import nsfc_pkg::*;

   localparam int LINE_CAP = 96;

   typedef struct packed {
      logic       checksum_ok;
      logic [7:0] computed_sum;
      logic [7:0] received_sum;
      logic [6:0] line_length;
      logic [1:0] sentence_kind;
      logic [4:0] field_count;
   } line_check_type;

   logic clock;
   logic reset;

   nsfc_req_if req_bus ();
   nsfc_rsp_if rsp_bus ();

   nmea_sentence_framer_checker #(.LINE_CAPACITY(LINE_CAP)) DUT (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   logic [7:0]     pending_bytes[$];
   line_check_type expected_lines[$];

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int bytes_queued = 0;
   int bytes_sent = 0;
   int lines_checked = 0;
   int lines_passing = 0;
   int gga_lines = 0;
   int rmc_lines = 0;
   int error_count = 0;

   string field_chars = "0123456789.-ABCDEFNSEWMabcxyz ";

   // Predictor state for the line being framed.
   int         line_len = 0;
   logic [7:0] xor_acc = 8'h00;
   logic [7:0] xor_at_star = 8'h00;
   logic       star_seen = 1'b0;
   int         after_star = 0;
   logic [7:0] hex_acc = 8'h00;
   logic       hex_live = 1'b0;
   logic [1:0] kind_cand = 2'b00;
   int         sep_count = 1;

   always #2 clock = ~clock;

   function automatic void clear_line_state();
      line_len    = 0;
      xor_acc     = 8'h00;
      xor_at_star = 8'h00;
      star_seen   = 1'b0;
      after_star  = 0;
      hex_acc     = 8'h00;
      hex_live    = 1'b0;
      kind_cand   = 2'b00;
      sep_count   = 1;
   endfunction

   // Advances the line state by one byte; returns 1 when the byte closes a
   // line long enough to be reported.
   function automatic bit predict_line_byte(input logic [7:0] c, output line_check_type res);
      bit produced;
      int idx;
      int nib;
      produced = 1'b0;
      res = '0;
      if (c == CHAR_DOLLAR) begin
         clear_line_state();
         line_len  = 1;
         kind_cand = 2'b11;
      end else if (c == CHAR_CR || c == CHAR_LF) begin
         if (line_len > MIN_REPORT_LEN) begin
            res.computed_sum  = star_seen ? xor_at_star : 8'h00;
            res.received_sum  = star_seen ? hex_acc : 8'h00;
            res.checksum_ok   = (line_len >= MIN_CHECK_LEN) && star_seen && (after_star >= 2)
                                && (res.computed_sum == res.received_sum);
            res.line_length   = 7'(line_len);
            res.sentence_kind = kind_cand[0] ? KIND_GGA : (kind_cand[1] ? KIND_RMC : KIND_OTHER);
            res.field_count   = 5'(sep_count);
            produced = 1'b1;
         end
         clear_line_state();
      end else if (line_len != 0 && line_len < LINE_CAP - 1) begin
         if (line_len >= KIND_POS_FIRST && line_len <= KIND_POS_FIRST + 2) begin
            idx = line_len - KIND_POS_FIRST;
            if (c != GGA_TEXT[23 - 8 * idx -: 8]) kind_cand[0] = 1'b0;
            if (c != RMC_TEXT[23 - 8 * idx -: 8]) kind_cand[1] = 1'b0;
         end
         if (c == CHAR_STAR) begin
            xor_at_star = xor_acc;
            star_seen   = 1'b1;
            after_star  = 0;
            hex_acc     = 8'h00;
            hex_live    = 1'b1;
         end else begin
            if (star_seen && after_star < 2) after_star++;
            if (hex_live) begin
               if (c >= "0" && c <= "9") nib = c - 8'h30;
               else if (c >= "a" && c <= "f") nib = c - 8'h57;
               else if (c >= "A" && c <= "F") nib = c - 8'h37;
               else nib = -1;
               if (nib < 0) hex_live = 1'b0;
               else hex_acc = {hex_acc[3:0], 4'(nib)};
            end
         end
         if ((c == CHAR_COMMA || c == CHAR_STAR) && sep_count < MAX_FIELDS) sep_count++;
         xor_acc = xor_acc ^ c;
         line_len++;
      end
      return produced;
   endfunction

   task automatic note_error(input string msg);
      error_count++;
      if (error_count <= 10) $display("ERROR at %0t: %s", $realtime, msg);
   endtask

   // Byte driver: a beat stays up until accepted; new beats follow the idle rate.
   always @(posedge clock) begin : byte_driver
      line_check_type res;
      if (reset) begin
         req_bus.valid   <= 1'b0;
         req_bus.rx_byte <= 8'h00;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            bytes_sent++;
            if (predict_line_byte(req_bus.rx_byte, res)) expected_lines.push_back(res);
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (pending_bytes.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               req_bus.valid   <= 1'b1;
               req_bus.rx_byte <= pending_bytes.pop_front();
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // Result monitor with random backpressure.
   always @(posedge clock) begin : result_monitor
      line_check_type got;
      line_check_type want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            got = '{rsp_bus.checksum_ok, rsp_bus.computed_sum, rsp_bus.received_sum,
                    rsp_bus.line_length, rsp_bus.sentence_kind, rsp_bus.field_count};
            if (expected_lines.size() == 0) begin
               note_error($sformatf("unexpected line result ok=%0b len=%0d",
                                    got.checksum_ok, got.line_length));
            end else begin
               want = expected_lines.pop_front();
               lines_checked++;
               if (want.checksum_ok) lines_passing++;
               if (want.sentence_kind == KIND_GGA) gga_lines++;
               if (want.sentence_kind == KIND_RMC) rmc_lines++;
               if (got.checksum_ok !== want.checksum_ok || got.computed_sum !== want.computed_sum
                   || got.received_sum !== want.received_sum
                   || got.line_length !== want.line_length
                   || got.sentence_kind !== want.sentence_kind
                   || got.field_count !== want.field_count) begin
                  note_error($sformatf({"line mismatch: expected ok=%0b comp=%02h recv=%02h ",
                                        "len=%0d kind=%0d fields=%0d, got ok=%0b comp=%02h ",
                                        "recv=%02h len=%0d kind=%0d fields=%0d"},
                                       want.checksum_ok, want.computed_sum, want.received_sum,
                                       want.line_length, want.sentence_kind, want.field_count,
                                       got.checksum_ok, got.computed_sum, got.received_sum,
                                       got.line_length, got.sentence_kind, got.field_count));
               end
            end
         end
         rsp_bus.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   task automatic push_byte(input logic [7:0] c);
      pending_bytes.push_back(c);
      bytes_queued++;
   endtask

   task automatic push_text(input string s);
      for (int i = 0; i < s.len(); i++) push_byte(s[i]);
   endtask

   function automatic logic [7:0] text_xor(input string s);
      logic [7:0] x;
      x = 8'h00;
      for (int i = 0; i < s.len(); i++) x ^= s[i];
      return x;
   endfunction

   function automatic logic [7:0] field_char();
      return field_chars[$urandom_range(0, field_chars.len() - 1)];
   endfunction

   // One sentence: talker, kind, fields (after an early star in tail_mode 7), then a checksum tail picked by tail_mode.
   task automatic push_sentence(input int kind_sel, input int n_fields, input int tail_mode);
      string      body;
      string      tail;
      logic [23:0] kind_text;
      logic [7:0] sum;
      int         pos;
      body = "";
      body = {body, string'(8'($urandom_range(8'h41, 8'h5A))),
              string'(8'($urandom_range(8'h41, 8'h5A)))};
      case (kind_sel)
         1: kind_text = GGA_TEXT;
         2: kind_text = RMC_TEXT;
         3: begin
            // Near miss: one letter of a known kind changed.
            kind_text = $urandom_range(0, 1) ? GGA_TEXT : RMC_TEXT;
            pos = $urandom_range(0, 2);
            kind_text[8 * pos +: 8] = (kind_text[8 * pos +: 8] == "Z") ? 8'h41
                                      : kind_text[8 * pos +: 8] + 8'd1;
         end
         default: kind_text = {8'($urandom_range(8'h41, 8'h5A)),
                               8'($urandom_range(8'h41, 8'h5A)),
                               8'($urandom_range(8'h41, 8'h5A))};
      endcase
      body = {body, string'(kind_text[23:16]), string'(kind_text[15:8]),
              string'(kind_text[7:0])};
      if (tail_mode == 7) body = {body, "*", string'(field_char())};
      for (int f = 0; f < n_fields; f++) begin
         body = {body, ","};
         repeat ($urandom_range(0, 6)) body = {body, string'(field_char())};
      end
      sum = text_xor(body);
      case (tail_mode)
         0, 7: tail = $sformatf("*%02X", sum);
         1: tail = $sformatf("*%02x", sum);
         2: tail = $sformatf("*%02X", sum ^ 8'($urandom_range(1, 255)));
         3: tail = "";
         4: tail = $urandom_range(0, 1) ? "*" : $sformatf("*%1X", sum[3:0]);
         5: tail = $sformatf("*0x%02X", sum);
         default: tail = $sformatf("*%0X%02X", $urandom_range(1, 4095), sum);
      endcase
      push_text({"$", body, tail});
      case ($urandom_range(0, 2))
         0: push_byte(CHAR_CR);
         1: push_byte(CHAR_LF);
         default: begin
            push_byte(CHAR_CR);
            push_byte(CHAR_LF);
         end
      endcase
   endtask

   task automatic fill_random(input int quota);
      int start;
      int pick;
      int tail_mode;
      start = bytes_queued;
      while (bytes_queued - start < quota) begin
         pick = $urandom_range(0, 99);
         if (pick < 70) begin
            tail_mode = $urandom_range(0, 99);
            if (tail_mode < 55) tail_mode = tail_mode % 2;
            else if (tail_mode < 65) tail_mode = 2;
            else tail_mode = $urandom_range(3, 7);
            push_sentence($urandom_range(0, 3),
                          ($urandom_range(0, 9) == 0) ? $urandom_range(15, 22)
                                                      : $urandom_range(0, 12),
                          tail_mode);
         end else if (pick < 78) begin
            // Loose bytes, mostly outside any line.
            repeat ($urandom_range(1, 6)) push_byte(8'($urandom_range(0, 255)));
         end else if (pick < 88) begin
            // Truncated line: short drop, restart by a later dollar, or a plain end.
            push_byte(CHAR_DOLLAR);
            repeat ($urandom_range(0, 12)) push_byte(field_char());
            case ($urandom_range(0, 2))
               0: push_byte(CHAR_CR);
               1: push_byte(CHAR_LF);
               default: ;
            endcase
         end else if (pick < 93) begin
            // Line that runs into the capacity limit.
            push_byte(CHAR_DOLLAR);
            repeat ($urandom_range(85, 130)) begin
               if ($urandom_range(0, 9) == 0) push_byte(CHAR_COMMA);
               else if ($urandom_range(0, 19) == 0) push_byte(CHAR_STAR);
               else push_byte(field_char());
            end
            push_byte(CHAR_CR);
         end else begin
            // Line of arbitrary byte values.
            push_byte(CHAR_DOLLAR);
            repeat ($urandom_range(5, 40)) push_byte(8'($urandom_range(0, 255)));
            push_byte(CHAR_CR);
         end
      end
   endtask

   // The sender holds off until every queued beat is out and every line
   // result has come back.
   task automatic wait_drained();
      while (pending_bytes.size() != 0 || req_bus.valid || expected_lines.size() != 0)
         @(negedge clock);
   endtask

   initial begin : stimulus
      string body;
      clock = 1'b0;
      reset = 1'b1;
      req_bus.valid   = 1'b0;
      req_bus.rx_byte = 8'h00;
      rsp_bus.ready   = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct = 30;
      recv_idle_pct = 65;

      // Stray line end and bytes with no line open.
      push_byte(CHAR_LF);
      push_text("zz");
      body = "GPGGA,123519,4807.038,N,01131.000,E,1,08,0.9,545.4,M";
      push_text({"$", body, $sformatf("*%02X", text_xor(body))});
      push_byte(CHAR_CR);
      push_byte(CHAR_LF);
      body = "GPRMC,225446,A,4916.45,N";
      push_text({"$", body, $sformatf("*%02x", text_xor(body))});
      push_byte(CHAR_LF);
      push_text("$GPGSV,1,2,3");
      push_byte(CHAR_CR);
      body = "GNGGA,1";
      push_text({"$", body, $sformatf("*%02X", text_xor(body) ^ 8'h5A)});
      push_byte(CHAR_CR);
      // A hex prefix is not skipped: the digit run stops at the x.
      push_text("$GPRMC,1*0x12");
      push_byte(CHAR_CR);
      body = "GPZDA,9";
      push_text({"$", body, $sformatf("*7%02X", text_xor(body))});
      push_byte(CHAR_CR);
      // Lengths 5 and 6 are dropped, 7 is reported but too short to pass.
      push_text("$GPGG");
      push_byte(CHAR_CR);
      push_text("$GPGGA");
      push_byte(CHAR_LF);
      push_text("$GPGGA,");
      push_byte(CHAR_CR);
      push_text("$AB*CD");
      push_byte(CHAR_CR);
      // A second dollar restarts the line.
      body = "GPRMC,5";
      push_text({"$GPG$", body, $sformatf("*%02X", text_xor(body))});
      push_byte(CHAR_CR);
      // Only the last star counts.
      body = "GP*12,AB";
      push_text({"$", body, $sformatf("*%02X", text_xor(body))});
      push_byte(CHAR_CR);
      push_byte(CHAR_DOLLAR);
      push_byte(8'h00);
      push_byte(8'hFF);
      push_text("GGA,1*00");
      push_byte(CHAR_CR);
      body = {"GPGSA", {20{","}}};
      push_text({"$", body, $sformatf("*%02X", text_xor(body))});
      push_byte(CHAR_CR);
      push_byte(CHAR_DOLLAR);
      repeat (110) push_byte("9");
      push_byte(CHAR_CR);
      wait_drained();

      fill_random(450);
      wait_drained();

      send_idle_pct = 65;
      recv_idle_pct = 30;
      fill_random(450);
      wait_drained();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      fill_random(450);
      wait_drained();

      repeat (12) @(posedge clock);
      $display("Sent %0d bytes and checked %0d line results", bytes_sent, lines_checked);
      $display("(%0d with a good checksum, %0d GGA, %0d RMC), %0d mismatches",
               lines_passing, gga_lines, rmc_lines, error_count);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   initial begin : watchdog
      #2ms;
      $display("Run timed out with %0d line results outstanding", expected_lines.size());
      $display("DONE: errors detected");
      $finish;
   end

endmodule
